>>> rtl/eahc_pkg.sv
// ----------------------------------------------------------------------------
// eahc_pkg
// Shared types, widths, register indexes and reset values for the
// environmental alert block.
// ----------------------------------------------------------------------------
`default_nettype none

package eahc_pkg;

  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned HUMID_W  = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned IDX_W    = 3;

  // Register indexes, one 32-bit word each.
  localparam logic [IDX_W-1:0] REG_TEMP_ALERT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_CLEAR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_HUMID_ALERT = 3'd2;
  localparam logic [IDX_W-1:0] REG_HUMID_CLEAR = 3'd3;
  localparam logic [IDX_W-1:0] REG_CONFIRM     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CLEAR       = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_ALERT_RST  = 16'sd3000;
  localparam logic signed [TEMP_W-1:0] TEMP_CLEAR_RST  = 16'sd2800;
  localparam logic [HUMID_W-1:0]       HUMID_ALERT_RST = 10'd700;
  localparam logic [HUMID_W-1:0]       HUMID_CLEAR_RST = 10'd650;
  localparam logic [TIME_W-1:0]        CONFIRM_RST     = 32'd60000;
  localparam logic [TIME_W-1:0]        CLEAR_RST       = 32'd120000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_alert;
    logic signed [TEMP_W-1:0] temp_clear;
    logic [HUMID_W-1:0]       humid_alert;
    logic [HUMID_W-1:0]       humid_clear;
    logic [TIME_W-1:0]        confirm_time;
    logic [TIME_W-1:0]        clear_time;
  } cfg_t;

  typedef struct packed {
    logic fire;     // an item moves from the input to the result register
    logic vacant;   // that item reports a vacant room
    logic alert;    // committed alert state
    logic running;  // confirm/clear timer running
    logic up;       // timer counts toward alert
  } status_t;

endpackage

`default_nettype wire

>>> rtl/eahc_if.sv
// ----------------------------------------------------------------------------
// eahc_if
// Valid/ready channels for evaluation samples and alert results.
// ----------------------------------------------------------------------------
`default_nettype none

interface eahc_sample_if;
  logic               valid;
  logic               ready;
  logic               room_vacant;
  logic               occupancy_unsure;
  logic               sensor_ok;
  logic signed [15:0] temperature;
  logic [9:0]         humidity;
  logic [31:0]        now_time;

  modport source (output valid, room_vacant, occupancy_unsure, sensor_ok,
                  temperature, humidity, now_time, input ready);
  modport sink   (input valid, room_vacant, occupancy_unsure, sensor_ok,
                  temperature, humidity, now_time, output ready);
endinterface

interface eahc_result_if;
  logic valid;
  logic ready;
  logic alert_on;
  logic changed;

  modport source (output valid, alert_on, changed, input ready);
  modport sink   (input valid, alert_on, changed, output ready);
endinterface

`default_nettype wire

>>> rtl/env_alert_hysteresis_confirm.sv
// ----------------------------------------------------------------------------
// env_alert_hysteresis_confirm
// Flow: a sample passes the input register, then is evaluated into the result
// register; a result that is not yet taken holds both registers.
// Throughput: one sample per cycle while results are taken; a held result stalls it.
// Reset: asynchronous, active low; alert off, timer idle, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module env_alert_hysteresis_confirm import eahc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  eahc_sample_if.sink            sample_i,
  eahc_result_if.source          result_o
);

  cfg_t    cfg;
  status_t status;

  eahc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  eahc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_i),
    .result_o (result_o),
    .status_o (status)
  );

  // The alert state moves only when a transaction is evaluated.
  a_alert_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.fire |=> $stable(status.alert))
    else $error("alert state changed without an evaluation");

  a_vacant_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire && status.vacant |=> !status.alert && !status.running)
    else $error("vacant room did not force the alert off");

  // The pending result always reflects the committed state.
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.alert_on == status.alert)
    else $error("result disagrees with the alert state");

  a_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.running |-> !status.up)
    else $error("timer direction set while the timer is idle");

endmodule

`default_nettype wire

>>> rtl/eahc_regs.sv
// ----------------------------------------------------------------------------
// eahc_regs
// APB register file holding the alert and clear thresholds and times.
// ----------------------------------------------------------------------------
`default_nettype none

module eahc_regs import eahc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg_o
);

  cfg_t             cfg_q;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_alert   <= TEMP_ALERT_RST;
      cfg_q.temp_clear   <= TEMP_CLEAR_RST;
      cfg_q.humid_alert  <= HUMID_ALERT_RST;
      cfg_q.humid_clear  <= HUMID_CLEAR_RST;
      cfg_q.confirm_time <= CONFIRM_RST;
      cfg_q.clear_time   <= CLEAR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TEMP_ALERT:  cfg_q.temp_alert   <= pwdata[TEMP_W-1:0];
        REG_TEMP_CLEAR:  cfg_q.temp_clear   <= pwdata[TEMP_W-1:0];
        REG_HUMID_ALERT: cfg_q.humid_alert  <= pwdata[HUMID_W-1:0];
        REG_HUMID_CLEAR: cfg_q.humid_clear  <= pwdata[HUMID_W-1:0];
        REG_CONFIRM:     cfg_q.confirm_time <= pwdata[TIME_W-1:0];
        REG_CLEAR:       cfg_q.clear_time   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_TEMP_ALERT:  prdata = {{(DATA_W-TEMP_W){cfg_q.temp_alert[TEMP_W-1]}},
                                 cfg_q.temp_alert};
      REG_TEMP_CLEAR:  prdata = {{(DATA_W-TEMP_W){cfg_q.temp_clear[TEMP_W-1]}},
                                 cfg_q.temp_clear};
      REG_HUMID_ALERT: prdata = {{(DATA_W-HUMID_W){1'b0}}, cfg_q.humid_alert};
      REG_HUMID_CLEAR: prdata = {{(DATA_W-HUMID_W){1'b0}}, cfg_q.humid_clear};
      REG_CONFIRM:     prdata = cfg_q.confirm_time;
      REG_CLEAR:       prdata = cfg_q.clear_time;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/eahc_core.sv
// ----------------------------------------------------------------------------
// eahc_core
// Input register, hysteresis and timer evaluation with the alert state,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eahc_core import eahc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  eahc_sample_if.sink  sample_i,
  eahc_result_if.source result_o,
  output      status_t status_o
);

  // Input register.
  logic                     s1_valid_q;
  logic                     s1_vacant_q;
  logic                     s1_unsure_q;
  logic                     s1_ok_q;
  logic signed [TEMP_W-1:0] s1_temp_q;
  logic [HUMID_W-1:0]       s1_humid_q;
  logic [TIME_W-1:0]        s1_now_q;

  // Alert and timer state.
  logic              alert_q, alert_d;
  logic              running_q, running_d;
  logic              up_q, up_d;
  logic [TIME_W-1:0] origin_q, origin_d;

  // Result register.
  logic out_valid_q;
  logic out_alert_q;
  logic out_changed_q;

  logic              fire;
  logic              want_up;
  logic              want_down;
  logic              restart;
  logic [TIME_W-1:0] origin_eff;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] need;
  logic              commit;

  assign fire           = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_vacant_q <= sample_i.room_vacant;
      s1_unsure_q <= sample_i.occupancy_unsure;
      s1_ok_q     <= sample_i.sensor_ok;
      s1_temp_q   <= sample_i.temperature;
      s1_humid_q  <= sample_i.humidity;
      s1_now_q    <= sample_i.now_time;
    end
  end

  assign want_up   = (s1_temp_q > cfg_i.temp_alert) || (s1_humid_q > cfg_i.humid_alert);
  assign want_down = (s1_temp_q < cfg_i.temp_clear) && (s1_humid_q < cfg_i.humid_clear);

  // A restart takes the current time as origin, so the elapsed time is zero.
  assign restart    = !running_q || (up_q != want_up);
  assign origin_eff = restart ? s1_now_q : origin_q;
  assign elapsed    = s1_now_q - origin_eff;
  assign need       = want_up ? cfg_i.confirm_time : cfg_i.clear_time;
  assign commit     = elapsed >= need;

  always_comb begin
    alert_d   = alert_q;
    running_d = 1'b0;
    up_d      = 1'b0;
    origin_d  = '0;
    if (s1_vacant_q) begin
      alert_d = 1'b0;
    end else if (s1_unsure_q || !s1_ok_q) begin
      alert_d = alert_q;
    end else if (want_up || want_down) begin
      if (commit) begin
        alert_d = want_up;
      end else begin
        running_d = 1'b1;
        up_d      = want_up;
        origin_d  = origin_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_q   <= 1'b0;
      running_q <= 1'b0;
      up_q      <= 1'b0;
      origin_q  <= '0;
    end else if (fire) begin
      alert_q   <= alert_d;
      running_q <= running_d;
      up_q      <= up_d;
      origin_q  <= origin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_alert_q   <= alert_d;
      out_changed_q <= alert_d != alert_q;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.alert_on = out_alert_q;
  assign result_o.changed  = out_changed_q;

  assign status_o.fire    = fire;
  assign status_o.vacant  = s1_vacant_q;
  assign status_o.alert   = alert_q;
  assign status_o.running = running_q;
  assign status_o.up      = up_q;

endmodule

`default_nettype wire
